@@ src/gwwl_pkg.sv @@
package gwwl_pkg;

   // default geometry of the text grid
   localparam int COLS_DEFAULT = 15;
   localparam int ROWS_DEFAULT = 4;

   // payload widths
   localparam int CHAR_W   = 8;
   localparam int COLUMN_W = 4;
   localparam int ROW_W    = 2;

   // character codes
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

   // action codes
   localparam logic ACTION_CHAR  = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

endpackage

@@ src/gwwl_req_if.sv @@
interface gwwl_req_if;
   import gwwl_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic [CHAR_W-1:0] in_char;
   logic              message_end;

   modport source (output valid, action, in_char, message_end, input ready);
   modport sink   (input valid, action, in_char, message_end, output ready);
endinterface

@@ src/gwwl_rsp_if.sv @@
interface gwwl_rsp_if;
   import gwwl_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   out_char;
   logic [COLUMN_W-1:0] column;
   logic [ROW_W-1:0]    row;
   logic                scrolled;
   logic                line_last;

   modport source (output valid, out_char, column, row, scrolled, line_last, input ready);
   modport sink   (input valid, out_char, column, row, scrolled, line_last, output ready);
endinterface

@@ src/greedy_word_wrap_line_log.sv @@
// Greedy word wrap into lines of COLS characters with a row log of ROWS lines.
// One character item is taken while the block is idle; ready stays low until
// the item is fully handled. A character that completes no line goes only
// through the append step. Each emitted line is sent as one read prime of the
// line buffer, then one character per cycle while the result side does not
// stall; a break at a space adds the advance step to rotate the buffer start.
// The worst item (a full line followed by a message-end flush) gives up to
// COLS + 1 results. The line buffer has a single read port, and one circular
// index adder serves every buffer access. A clear item produces no results.
// The line buffer holds no reset value.
module greedy_word_wrap_line_log #(
   parameter int COLS = gwwl_pkg::COLS_DEFAULT,
   parameter int ROWS = gwwl_pkg::ROWS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   gwwl_req_if.sink   req_chan,
   gwwl_rsp_if.source rsp_chan
);
   import gwwl_pkg::*;

   localparam int IDX_W   = $clog2(COLS);
   localparam int CNT_W   = $clog2(COLS + 1);
   localparam int LINES_W = $clog2(ROWS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_PRIME,
      ST_OUT,
      ST_ADV
   } state_type;

   state_type         state_ff, state_in;
   state_type         after_ff, after_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  lsp_ff, lsp_in;
   logic [IDX_W-1:0]  base_ff, base_in;
   logic [LINES_W-1:0] lines_ff, lines_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [LINES_W-1:0] row_ff, row_in;
   logic              scr_ff, scr_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              end_ff, end_in;

   logic              req_fire;
   logic              rsp_fire;
   logic [CNT_W-1:0]  offset;
   logic [IDX_W-1:0]  index;
   logic              wr_en;
   logic [CHAR_W-1:0] rd_data;
   logic [CNT_W-1:0]  fill_new;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_OUT);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // shared circular index adder for every buffer access
   gwwl_index_unit #(.COLS(COLS)) u_index (
      .base   (base_ff),
      .offset (offset),
      .index  (index)
   );

   gwwl_ram #(.WIDTH(CHAR_W), .DEPTH(COLS)) u_line_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (index),
      .wr_data (char_ff),
      .rd_addr (index),
      .rd_data (rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      fill_in  = fill_ff;
      lsp_in   = lsp_ff;
      base_in  = base_ff;
      lines_in = lines_ff;
      len_in   = len_ff;
      k_in     = k_ff;
      row_in   = row_ff;
      scr_in   = scr_ff;
      char_in  = char_ff;
      end_in   = end_ff;
      offset   = '0;
      wr_en    = 1'b0;
      fill_new = fill_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.action == ACTION_CLEAR) begin
                  lines_in = '0;
               end else begin
                  char_in = req_chan.in_char;
                  end_in  = req_chan.message_end;
                  if (fill_ff == CNT_W'(COLS)) begin
                     // full line: break at last space or hard split
                     if (req_chan.in_char != SPACE_CHAR && lsp_ff != '0) begin
                        len_in   = CNT_W'(lsp_ff);
                        after_in = ST_ADV;
                     end else begin
                        len_in   = CNT_W'(COLS);
                        after_in = ST_APPEND;
                        fill_in  = '0;
                        lsp_in   = '0;
                     end
                     state_in = ST_PRIME;
                  end else begin
                     state_in = ST_APPEND;
                  end
               end
            end
         end

         ST_APPEND: begin
            // leading spaces of a line are dropped
            offset = fill_ff;
            wr_en  = !(fill_ff == '0 && char_ff == SPACE_CHAR);
            if (wr_en) begin
               fill_new = fill_ff + CNT_W'(1);
               if (char_ff == SPACE_CHAR) begin
                  lsp_in = fill_ff[IDX_W-1:0];
               end
            end
            fill_in = fill_new;
            if (end_ff && fill_new != '0) begin
               len_in   = fill_new;
               fill_in  = '0;
               lsp_in   = '0;
               after_in = ST_IDLE;
               state_in = ST_PRIME;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_PRIME: begin
            // issue read of the first character, place the line in the grid
            offset = '0;
            k_in   = '0;
            if (lines_ff >= LINES_W'(ROWS)) begin
               row_in   = LINES_W'(ROWS - 1);
               scr_in   = 1'b1;
               lines_in = LINES_W'(ROWS);
            end else begin
               row_in   = lines_ff;
               scr_in   = 1'b0;
               lines_in = lines_ff + LINES_W'(1);
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            // read address runs one ahead once the current item is taken
            offset = k_ff + CNT_W'(rsp_fire);
            if (rsp_fire) begin
               if (k_ff + CNT_W'(1) == len_ff) begin
                  state_in = after_ff;
               end else begin
                  k_in = k_ff + CNT_W'(1);
               end
            end
         end

         ST_ADV: begin
            // carry text after the break space to the line start
            offset   = CNT_W'(lsp_ff) + CNT_W'(1);
            base_in  = index;
            fill_in  = CNT_W'(COLS - 1) - CNT_W'(lsp_ff);
            lsp_in   = '0;
            state_in = ST_APPEND;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= ST_IDLE;
         fill_ff  <= '0;
         lsp_ff   <= '0;
         base_ff  <= '0;
         lines_ff <= '0;
         len_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         fill_ff  <= fill_in;
         lsp_ff   <= lsp_in;
         base_ff  <= base_in;
         lines_ff <= lines_in;
         len_ff   <= len_in;
         k_ff     <= k_in;
      end
      row_ff  <= row_in;
      scr_ff  <= scr_in;
      char_ff <= char_in;
      end_ff  <= end_in;
   end

   // result payload
   assign rsp_chan.out_char  = rd_data;
   assign rsp_chan.column    = COLUMN_W'(k_ff);
   assign rsp_chan.row       = ROW_W'(row_ff);
   assign rsp_chan.scrolled  = scr_ff;
   assign rsp_chan.line_last = (k_ff + CNT_W'(1) == len_ff);
endmodule

@@ src/gwwl_ram.sv @@
module gwwl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ src/gwwl_index_unit.sv @@
module gwwl_index_unit #(
   parameter int COLS = gwwl_pkg::COLS_DEFAULT
) (
   input  logic [$clog2(COLS)-1:0]   base,
   input  logic [$clog2(COLS+1)-1:0] offset,
   output logic [$clog2(COLS)-1:0]   index
);
   import gwwl_pkg::*;

   localparam int IDX_W = $clog2(COLS);
   localparam int CNT_W = $clog2(COLS + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] fold;

   // circular position: base plus offset, folded once into the buffer depth
   assign sum   = SUM_W'(base) + SUM_W'(offset);
   assign fold  = (sum >= SUM_W'(COLS)) ? (sum - SUM_W'(COLS)) : sum;
   assign index = fold[IDX_W-1:0];
endmodule

@@ src/gwwl_checker.sv @@
module gwwl_checker #(
   parameter int ROWS = gwwl_pkg::ROWS_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [gwwl_pkg::CHAR_W-1:0]   out_char,
   input logic [gwwl_pkg::COLUMN_W-1:0] column,
   input logic [gwwl_pkg::ROW_W-1:0]    row,
   input logic                          scrolled,
   input logic                          line_last
);
   import gwwl_pkg::*;

   // no new item while a line is going out
   a_busy_while_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while results pending");

   // characters of one line go out back to back in column order
   a_column_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !line_last) |=>
         (rsp_valid && column == COLUMN_W'($past(column) + COLUMN_W'(1))))
      else $error("column did not advance within a line");

   // placement holds for the whole line
   a_line_placement: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !line_last) |=>
         (row == $past(row) && scrolled == $past(scrolled)))
      else $error("row or scroll flag changed within a line");

   // scrolled lines always land in the last row
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && scrolled) |-> (row == ROW_W'(ROWS - 1)))
      else $error("scrolled line not in last row");

   // stalled result character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_char)))
      else $error("stalled result changed");
endmodule

bind greedy_word_wrap_line_log gwwl_checker #(.ROWS(ROWS)) u_gwwl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_char  (rsp_chan.out_char),
   .column    (rsp_chan.column),
   .row       (rsp_chan.row),
   .scrolled  (rsp_chan.scrolled),
   .line_last (rsp_chan.line_last)
);
